[hdl/ewmab_pkg.sv]
// ewmab_pkg: shared widths, constants, register indexes and control codes
// for the ewma demand bandwidth allocator
// no dependencies
package ewmab_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int COUNT_BITS    = 32;

  localparam int DATA_W    = 32;
  localparam int ALPHA_W   = 17;
  localparam int DEMAND_W  = DATA_W + FRACTION_BITS;
  localparam int OHI_W     = DEMAND_W - 16;
  localparam int FRAC_W    = FRACTION_BITS + 1;
  localparam int MUL_A_W   = (FRAC_W > ALPHA_W) ? FRAC_W : ALPHA_W;
  localparam int MUL_B_W   = (OHI_W > DATA_W) ? OHI_W : DATA_W;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = 64;
  localparam int LO_W      = 34;
  localparam int SUM_W     = 64;
  localparam int DIVR_W    = (COUNT_BITS > DATA_W) ? COUNT_BITS : DATA_W;
  localparam int ITER_W    = $clog2(DATA_W + 1);
  localparam int CFG_IDX_W = 8;

  // the a*q term is shifted up for wide fractions, or split for narrow ones
  localparam int T1_SHIFT = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : FRACTION_BITS;
  localparam bit T1_SPLIT = (FRACTION_BITS < 16);

  localparam logic [ALPHA_W-1:0]    ALPHA_ONE = {1'b1, {(ALPHA_W-1){1'b0}}};
  localparam logic [FRAC_W-1:0]     FRAC_ONE  = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [ALPHA_W-1:0] SMOOTHING_RESET = ALPHA_W'(19661);
  localparam logic [DATA_W-1:0]  MIN_BW_RESET    = DATA_W'(50000000);
  localparam logic [DATA_W-1:0]  MAX_BW_RESET    = DATA_W'(500000000);
  localparam logic [DATA_W-1:0]  SAT_RESET       = DATA_W'(62500);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMOOTHING  = 8'd0,
    REG_MIN_BW     = 8'd1,
    REG_MAX_BW     = 8'd2,
    REG_SATURATION = 8'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL_AQ,
    OP_MUL_BH,
    OP_MUL_BL,
    OP_EWMA,
    OP_DIV1_LOAD,
    OP_DIV_STEP,
    OP_FRAC,
    OP_BW_MUL,
    OP_BW_ADD,
    OP_ACCUM,
    OP_DIV2_LOAD,
    OP_OUT_LOAD
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_BH,
    ST_MUL_BL,
    ST_EWMA,
    ST_DIV1_LOAD,
    ST_DIV1,
    ST_FRAC,
    ST_BW_MUL,
    ST_BW_ADD,
    ST_ACCUM,
    ST_DIV2_LOAD,
    ST_DIV2,
    ST_DONE
  } ctrl_state_t;

endpackage

[hdl/ewmab_if.sv]
// ewmab channel interfaces: demand requests, allocation results, register writes
// depends on ewmab_pkg
interface ewmab_demand_if;
  import ewmab_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] queue_bytes;
  modport source (output valid, output queue_bytes, input ready);
  modport sink (input valid, input queue_bytes, output ready);
endinterface

interface ewmab_alloc_if;
  import ewmab_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] bandwidth_hz;
  logic [DATA_W-1:0] mean_bandwidth_hz;
  logic [DATA_W-1:0] demand_estimate;
  modport source (output valid, output bandwidth_hz, output mean_bandwidth_hz,
                  output demand_estimate, input ready);
  modport sink (input valid, input bandwidth_hz, input mean_bandwidth_hz,
                input demand_estimate, output ready);
endinterface

interface ewmab_cfg_if;
  import ewmab_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/ewmab_ctrl.sv]
// ewmab_ctrl: sequencer for one request, drives datapath ops and the
// request/result handshakes; depends on ewmab_pkg
module ewmab_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            demand_valid,
  output logic            demand_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  logic            early_clamp,
  output ewmab_pkg::dp_op_t op
);
  import ewmab_pkg::*;

  ctrl_state_t       state, state_next;
  logic [ITER_W-1:0] iter, iter_next;
  logic              out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      iter      <= iter_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    iter_next      = iter;
    op             = OP_NONE;
    demand_ready   = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        demand_ready = 1'b1;
        if (demand_valid) begin
          op         = OP_MUL_AQ;
          state_next = ST_MUL_BH;
        end
      end
      ST_MUL_BH: begin
        op         = OP_MUL_BH;
        state_next = ST_MUL_BL;
      end
      ST_MUL_BL: begin
        op         = OP_MUL_BL;
        state_next = ST_EWMA;
      end
      ST_EWMA: begin
        op         = OP_EWMA;
        state_next = ST_DIV1_LOAD;
      end
      ST_DIV1_LOAD: begin
        op        = OP_DIV1_LOAD;
        iter_next = ITER_W'(FRAC_W);
        // demand at or past twice the saturation size, or a zero saturation size, skips the division
        state_next = early_clamp ? ST_BW_MUL : ST_DIV1;
      end
      ST_DIV1: begin
        op        = OP_DIV_STEP;
        iter_next = iter - 1'b1;
        if (iter == ITER_W'(1)) begin
          state_next = ST_FRAC;
        end
      end
      ST_FRAC: begin
        op         = OP_FRAC;
        state_next = ST_BW_MUL;
      end
      ST_BW_MUL: begin
        op         = OP_BW_MUL;
        state_next = ST_BW_ADD;
      end
      ST_BW_ADD: begin
        op         = OP_BW_ADD;
        state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        op         = OP_ACCUM;
        state_next = ST_DIV2_LOAD;
      end
      ST_DIV2_LOAD: begin
        op         = OP_DIV2_LOAD;
        iter_next  = ITER_W'(DATA_W);
        state_next = ST_DIV2;
      end
      ST_DIV2: begin
        op        = OP_DIV_STEP;
        iter_next = iter - 1'b1;
        if (iter == ITER_W'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          op             = OP_OUT_LOAD;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !out_valid) |=> out_valid)
    else $error("finished result not loaded into output register");

  a_iter_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV1 || state == ST_DIV2) |-> iter != '0)
    else $error("division iteration counter ran out");

endmodule

[hdl/ewmab_dp.sv]
// ewmab_dp: configuration registers, shared multiplier, shared restoring
// divider, ewma and allocation state, result register; depends on ewmab_pkg
module ewmab_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  ewmab_pkg::dp_op_t                 op,
  output logic                              early_clamp,
  input  logic                              cfg_we,
  input  logic [ewmab_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ewmab_pkg::DATA_W-1:0]      cfg_data,
  input  logic [ewmab_pkg::DATA_W-1:0]      queue_bytes,
  output logic [ewmab_pkg::DATA_W-1:0]      bandwidth_hz,
  output logic [ewmab_pkg::DATA_W-1:0]      mean_bandwidth_hz,
  output logic [ewmab_pkg::DATA_W-1:0]      demand_estimate
);
  import ewmab_pkg::*;

  logic [ALPHA_W-1:0]    smoothing;
  logic [DATA_W-1:0]     min_bw, max_bw, sat_bytes;

  logic [DEMAND_W-1:0]   demand;
  logic [SUM_W-1:0]      alloc_sum;
  logic [COUNT_BITS-1:0] count;

  logic [PROD_W-1:0]     p;
  logic [ACC_W-1:0]      acc;
  logic [15:0]           lo;
  logic [FRAC_W-1:0]     frac;
  logic [DATA_W-1:0]     bw;
  logic [DIVR_W-1:0]     rem, divisor;
  logic [DATA_W-1:0]     quo;

  logic [ALPHA_W-1:0]    alpha_sat, beta;
  logic [DATA_W-1:0]     span;
  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [PROD_W-1:0]     product;
  logic [ACC_W-1:0]      t1_shift;
  logic [LO_W-1:0]       lo_sum;
  logic [DIVR_W:0]       shifted;
  logic                  div_ge;
  logic [SUM_W:0]        sum_add;
  logic [FRAC_W-1:0]     quot_frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing <= SMOOTHING_RESET;
      min_bw    <= MIN_BW_RESET;
      max_bw    <= MAX_BW_RESET;
      sat_bytes <= SAT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SMOOTHING:  smoothing <= cfg_data[ALPHA_W-1:0];
        REG_MIN_BW:     min_bw    <= cfg_data;
        REG_MAX_BW:     max_bw    <= cfg_data;
        REG_SATURATION: sat_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  assign alpha_sat = (smoothing > ALPHA_ONE) ? ALPHA_ONE : smoothing;
  assign beta      = ALPHA_ONE - alpha_sat;
  assign span      = (max_bw >= min_bw) ? (max_bw - min_bw) : '0;

  // quotient reaches 2^(FRAC_W) or more once the top part alone covers the divisor
  assign early_clamp = (sat_bytes == '0) || ((demand >> FRAC_W) >= DEMAND_W'(sat_bytes));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_MUL_AQ: begin
        mul_a = MUL_A_W'(alpha_sat);
        mul_b = MUL_B_W'(queue_bytes);
      end
      OP_MUL_BH: begin
        mul_a = MUL_A_W'(beta);
        mul_b = MUL_B_W'(demand[DEMAND_W-1:16]);
      end
      OP_MUL_BL: begin
        mul_a = MUL_A_W'(beta);
        mul_b = MUL_B_W'(demand[15:0]);
      end
      OP_BW_MUL: begin
        mul_a = MUL_A_W'(frac);
        mul_b = MUL_B_W'(span);
      end
      default: ;
    endcase
  end

  assign product   = mul_a * mul_b;
  assign t1_shift  = ACC_W'(p) << T1_SHIFT;
  assign lo_sum    = LO_W'(lo) + LO_W'(p);
  assign shifted   = {rem, quo[DATA_W-1]};
  assign div_ge    = shifted >= {1'b0, divisor};
  assign sum_add   = {1'b0, alloc_sum} + (SUM_W+1)'(bw);
  assign quot_frac = quo[FRAC_W-1:0];

  always_ff @(posedge clk) begin
    if (op == OP_MUL_AQ || op == OP_MUL_BH || op == OP_MUL_BL || op == OP_BW_MUL) begin
      p <= product;
    end
    case (op)
      OP_MUL_BH: begin
        if (T1_SPLIT) begin
          acc <= t1_shift >> 16;
          lo  <= t1_shift[15:0];
        end else begin
          acc <= t1_shift;
          lo  <= '0;
        end
      end
      OP_MUL_BL: acc <= acc + ACC_W'(p);
      OP_DIV1_LOAD: begin
        frac    <= FRAC_ONE;
        rem     <= DIVR_W'(demand >> FRAC_W);
        divisor <= DIVR_W'(sat_bytes);
        quo     <= {demand[FRAC_W-1:0], {(DATA_W-FRAC_W){1'b0}}};
      end
      OP_DIV_STEP: begin
        rem <= div_ge ? DIVR_W'(shifted - {1'b0, divisor}) : shifted[DIVR_W-1:0];
        quo <= {quo[DATA_W-2:0], div_ge};
      end
      OP_FRAC: frac <= (quot_frac > FRAC_ONE) ? FRAC_ONE : quot_frac;
      OP_BW_ADD: bw <= min_bw + DATA_W'(p >> FRACTION_BITS);
      OP_DIV2_LOAD: begin
        rem     <= DIVR_W'(alloc_sum[SUM_W-1:DATA_W]);
        quo     <= alloc_sum[DATA_W-1:0];
        divisor <= DIVR_W'(count);
      end
      OP_OUT_LOAD: begin
        bandwidth_hz      <= bw;
        mean_bandwidth_hz <= (count == '0) ? '0 : quo;
        demand_estimate   <= demand[FRACTION_BITS +: DATA_W];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      demand    <= '0;
      alloc_sum <= '0;
      count     <= '0;
    end else begin
      if (op == OP_EWMA) begin
        demand <= DEMAND_W'(acc + ACC_W'(lo_sum >> 16));
      end
      // a full count freezes both the sum and the count
      if (op == OP_ACCUM && count != COUNT_MAX) begin
        alloc_sum <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        count     <= count + 1'b1;
      end
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (op == OP_DIV_STEP) |-> (rem < divisor))
    else $error("divider remainder not below divisor");

  a_frac_clamped: assert property (@(posedge clk) disable iff (rst)
    (op == OP_BW_MUL) |-> (frac <= FRAC_ONE))
    else $error("demand fraction above one");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    ($past(op == OP_ACCUM) && !$past(rst)) |-> (count != '0))
    else $error("allocation count zero after update");

endmodule

[hdl/ewma_demand_bandwidth_allocator_unit.sv]
// ewma_demand_bandwidth_allocator_unit: top level, joins controller and datapath
// to the channel interfaces; depends on ewmab_pkg, ewmab_if, ewmab_ctrl, ewmab_dp
//
// Each request on the demand channel carries the queue occupancy of one
// update interval. The block folds it into an exponentially weighted demand
// estimate, maps the estimate against the saturation size onto the range
// from minimum to maximum bandwidth, and returns one result on the alloc
// channel: the new bandwidth, the running mean of all bandwidths so far and
// the integer demand estimate.
// One request is worked on at a time, and the next request is taken the
// cycle after the result is loaded. The shared restoring divider makes one
// quotient bit per cycle: 17 bits for the demand fraction and 32 for the
// mean; the fraction division is skipped when the estimate is at least twice
// the saturation size or the saturation size is zero.
// The result waits in an output register; a stalled receiver holds it there
// while the next request is already taken and worked on, and only the load of
// that next result waits. Registers are written on the cfg channel (always
// ready); the user must write them only while no request is in flight, as the
// block does not enforce it. Reset loads the register defaults and clears
// the demand estimate, the bandwidth sum and the count.
module ewma_demand_bandwidth_allocator_unit (
  input  logic          clk,
  input  logic          rst,
  ewmab_demand_if.sink  demand,
  ewmab_alloc_if.source alloc,
  ewmab_cfg_if.sink     cfg
);
  import ewmab_pkg::*;

  dp_op_t op;
  logic   early_clamp;

  assign cfg.ready = 1'b1;

  ewmab_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .demand_valid (demand.valid),
    .demand_ready (demand.ready),
    .out_valid    (alloc.valid),
    .out_ready    (alloc.ready),
    .early_clamp  (early_clamp),
    .op           (op)
  );

  ewmab_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .op                (op),
    .early_clamp       (early_clamp),
    .cfg_we            (cfg.valid),
    .cfg_index         (cfg.index),
    .cfg_data          (cfg.data),
    .queue_bytes       (demand.queue_bytes),
    .bandwidth_hz      (alloc.bandwidth_hz),
    .mean_bandwidth_hz (alloc.mean_bandwidth_hz),
    .demand_estimate   (alloc.demand_estimate)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (demand.valid && demand.ready) |=> !demand.ready)
    else $error("second request taken while one is in flight");

endmodule

[tb/ewma_demand_bandwidth_allocator_unit_tb.sv]
// testbench for ewma_demand_bandwidth_allocator_unit: random demand and register traffic,
// results checked against an in-line allocation predictor
// depends on ewmab_pkg, ewmab_if and the allocator rtl
module ewma_demand_bandwidth_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ewmab_pkg::*;

  localparam int MIX_W = DEMAND_W + ALPHA_W + 2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd9;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AT = 40;

  typedef logic [MIX_W-1:0] mix_t;

  typedef struct packed {
    logic [DATA_W-1:0] bandwidth_hz;
    logic [DATA_W-1:0] mean_bandwidth_hz;
    logic [DATA_W-1:0] demand_estimate;
  } alloc_t;

  typedef struct {
    bit                   is_write;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;
    int                   gap;
  } req_op_t;

  logic clk = 1'b0;
  logic rst;

  ewmab_demand_if dem_ch ();
  ewmab_alloc_if  alloc_ch ();
  ewmab_cfg_if    cfg_ch ();

  ewma_demand_bandwidth_allocator_unit u_top (
    .clk   (clk),
    .rst   (rst),
    .demand(dem_ch),
    .alloc (alloc_ch),
    .cfg   (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  req_op_t request_queue[$];
  alloc_t  pending_allocs[$];

  // predictor copy of the registers and the running state
  logic [ALPHA_W-1:0]    alpha_reg;
  logic [DATA_W-1:0]     min_hz;
  logic [DATA_W-1:0]     max_hz;
  logic [DATA_W-1:0]     sat_bytes;
  logic [DEMAND_W-1:0]   est_demand;
  logic [SUM_W-1:0]      bw_total;
  logic [COUNT_BITS-1:0] bw_count;

  int mismatches = 0;
  int results_seen;
  int gap_left;
  int recv_wait;
  int stall_cycles;
  bit stall_armed;

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    case (idx)
      REG_SMOOTHING:  alpha_reg = data[ALPHA_W-1:0];
      REG_MIN_BW:     min_hz = data;
      REG_MAX_BW:     max_hz = data;
      REG_SATURATION: sat_bytes = data;
      default: ;
    endcase
  endtask

  task automatic predict_allocation(input logic [DATA_W-1:0] q, output alloc_t res);
    logic [ALPHA_W-1:0] a;
    logic [ALPHA_W-1:0] b;
    mix_t               mix;
    logic [63:0]        frac;
    logic [63:0]        span;
    logic [63:0]        bw;
    a = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    b = ALPHA_ONE - a;
    // exact weighted sum of new sample and old estimate, then drop the Q1.16 weight scale
    mix = mix_t'(a) * (mix_t'(q) << FRACTION_BITS) + mix_t'(b) * mix_t'(est_demand);
    est_demand = DEMAND_W'(mix >> (ALPHA_W - 1));
    if (sat_bytes == '0) begin
      frac = 64'(FRAC_ONE);
    end else begin
      frac = 64'(est_demand) / 64'(sat_bytes);
      if (frac > 64'(FRAC_ONE)) frac = 64'(FRAC_ONE);
    end
    span = (max_hz >= min_hz) ? 64'(max_hz) - 64'(min_hz) : 64'd0;
    bw = 64'(min_hz) + ((frac * span) >> FRACTION_BITS);
    res.bandwidth_hz = bw[DATA_W-1:0];
    if (bw_count < COUNT_MAX) begin
      if (bw_total > {SUM_W{1'b1}} - SUM_W'(res.bandwidth_hz)) bw_total = '1;
      else bw_total = bw_total + SUM_W'(res.bandwidth_hz);
      bw_count = bw_count + 1'b1;
    end
    res.mean_bandwidth_hz = (bw_count != '0) ? DATA_W'(bw_total / bw_count) : '0;
    res.demand_estimate = DATA_W'(est_demand >> FRACTION_BITS);
  endtask

  task automatic push_demand(input logic [DATA_W-1:0] q, input bit calm);
    req_op_t op;
    op.is_write = 1'b0;
    op.index = '0;
    op.data = q;
    op.gap = calm ? 0 : $urandom_range(0, 12);
    request_queue.push_back(op);
  endtask

  task automatic push_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    req_op_t op;
    op.is_write = 1'b1;
    op.index = idx;
    op.data = data;
    op.gap = 0;
    request_queue.push_back(op);
  endtask

  // request and register write driver
  always @(posedge clk) begin : drive_requests
    req_op_t op;
    logic    dv;
    logic    cv;
    if (rst) begin
      dem_ch.valid <= 1'b0;
      dem_ch.queue_bytes <= '0;
      cfg_ch.valid <= 1'b0;
      cfg_ch.index <= '0;
      cfg_ch.data <= '0;
      gap_left = -1;
    end else begin
      dv = dem_ch.valid && !dem_ch.ready;
      cv = cfg_ch.valid && !cfg_ch.ready;
      if (!dv && !cv && request_queue.size() != 0) begin
        op = request_queue[0];
        if (op.is_write) begin
          // register writes wait until nothing is in flight or unclaimed
          if (!dem_ch.valid && !alloc_ch.valid && pending_allocs.size() == 0) begin
            void'(request_queue.pop_front());
            cfg_ch.index <= op.index;
            cfg_ch.data <= op.data;
            cv = 1'b1;
          end
        end else begin
          if (gap_left < 0) gap_left = op.gap;
          if (gap_left == 0) begin
            void'(request_queue.pop_front());
            dem_ch.queue_bytes <= op.data;
            dv = 1'b1;
            gap_left = -1;
          end else if (dem_ch.ready || stall_cycles != 0) begin
            // the gap runs while the block could take a request, or during the hold-off
            gap_left = gap_left - 1;
          end
        end
      end
      dem_ch.valid <= dv;
      cfg_ch.valid <= cv;
    end
  end

  // result receiver, stalls counted from the arrival of a result
  always @(posedge clk) begin : take_allocs
    if (rst) begin
      alloc_ch.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (alloc_ch.valid && alloc_ch.ready)
        recv_wait = (((results_seen >> 6) % 4) == 2) ? 0 : $urandom_range(0, 12);
      else if (alloc_ch.valid && recv_wait > 0)
        recv_wait = recv_wait - 1;
      alloc_ch.ready <= (recv_wait == 0) && (stall_cycles == 0);
    end
  end

  // one long receiver hold-off so the block backs up into the request side
  always @(posedge clk) begin : hold_off
    if (rst) begin
      stall_cycles <= 0;
      stall_armed <= 1'b1;
    end else if (stall_armed && results_seen == HOLD_OFF_AT) begin
      stall_cycles <= HOLD_OFF_CYCLES;
      stall_armed <= 1'b0;
    end else if (stall_cycles != 0) begin
      stall_cycles <= stall_cycles - 1;
    end
  end

  always @(posedge clk) begin : check_allocs
    alloc_t want;
    alloc_t got;
    if (rst) begin
      alpha_reg = SMOOTHING_RESET;
      min_hz = MIN_BW_RESET;
      max_hz = MAX_BW_RESET;
      sat_bytes = SAT_RESET;
      est_demand = '0;
      bw_total = '0;
      bw_count = '0;
      results_seen <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) apply_write(cfg_ch.index, cfg_ch.data);
      if (dem_ch.valid && dem_ch.ready) begin
        predict_allocation(dem_ch.queue_bytes, want);
        pending_allocs.push_back(want);
      end
      if (alloc_ch.valid && alloc_ch.ready) begin
        results_seen <= results_seen + 1;
        got.bandwidth_hz = alloc_ch.bandwidth_hz;
        got.mean_bandwidth_hz = alloc_ch.mean_bandwidth_hz;
        got.demand_estimate = alloc_ch.demand_estimate;
        if (pending_allocs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected alloc result: bw %0d mean %0d demand %0d",
                     got.bandwidth_hz, got.mean_bandwidth_hz, got.demand_estimate);
        end else begin
          want = pending_allocs.pop_front();
          if (got.bandwidth_hz !== want.bandwidth_hz ||
              got.mean_bandwidth_hz !== want.mean_bandwidth_hz ||
              got.demand_estimate !== want.demand_estimate) begin
            mismatches++;
            if (mismatches <= 10)
              $display("alloc mismatch (exp/got): bw %0d/%0d mean %0d/%0d demand %0d/%0d",
                       want.bandwidth_hz, got.bandwidth_hz,
                       want.mean_bandwidth_hz, got.mean_bandwidth_hz,
                       want.demand_estimate, got.demand_estimate);
          end
        end
      end
    end
  end

  initial begin : run_test
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] swap;
    logic [DATA_W-1:0] sat_pick;
    logic [DATA_W-1:0] q;
    bit                calm;
    rst = 1'b1;
    dem_ch.valid = 1'b0;
    dem_ch.queue_bytes = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    alloc_ch.ready = 1'b0;

    // reset defaults: empty, full and saturating demand
    push_demand('0, 1'b0);
    push_demand('1, 1'b0);
    push_demand('1, 1'b0);
    push_demand(32'd62500, 1'b0);
    push_demand('0, 1'b0);
    push_demand(32'd1, 1'b0);
    push_demand(32'h8000_0000, 1'b0);
    // weight exactly one, full bandwidth range
    push_write(REG_SMOOTHING, 32'(ALPHA_ONE));
    push_write(REG_MIN_BW, '0);
    push_write(REG_MAX_BW, '1);
    push_write(REG_SATURATION, '1);
    push_demand('1, 1'b0);
    push_demand('0, 1'b0);
    push_demand('1, 1'b0);
    // weight above one, zero saturation size
    push_write(REG_SMOOTHING, '1);
    push_write(REG_SATURATION, '0);
    push_demand(32'd5, 1'b0);
    push_demand(32'h1234_5678, 1'b0);
    // zero weight, maximum below minimum, write to an unused index
    push_write(REG_SMOOTHING, '0);
    push_write(REG_MIN_BW, '1);
    push_write(REG_MAX_BW, '0);
    push_write(REG_SATURATION, 32'd1);
    push_write(REG_SPARE, '1);
    push_demand('1, 1'b0);
    push_demand(32'd7, 1'b0);
    // smallest weight, equal bounds
    push_write(REG_SMOOTHING, 32'd1);
    push_write(REG_MIN_BW, 32'd1000);
    push_write(REG_MAX_BW, 32'd1000);
    push_demand('1, 1'b0);
    // weight just above one, demand around a small saturation size
    push_write(REG_SMOOTHING, 32'(ALPHA_ONE) + 32'd1);
    push_write(REG_MIN_BW, 32'd10);
    push_write(REG_MAX_BW, 32'h8000_0000);
    push_write(REG_SATURATION, 32'd100);
    push_demand(32'd150, 1'b0);
    push_demand(32'd50, 1'b0);

    for (int p = 0; p < 12; p++) begin
      calm = (p % 3 == 1);
      case ($urandom_range(0, 4))
        0: push_write(REG_SMOOTHING, '0);
        1: push_write(REG_SMOOTHING, 32'(ALPHA_ONE));
        2: push_write(REG_SMOOTHING, $urandom);
        default: push_write(REG_SMOOTHING, $urandom_range(1, 65535));
      endcase
      lo = $urandom;
      hi = $urandom;
      if ($urandom_range(0, 3) != 0 && lo > hi) begin
        swap = lo;
        lo = hi;
        hi = swap;
      end
      push_write(REG_MIN_BW, lo);
      push_write(REG_MAX_BW, hi);
      case ($urandom_range(0, 5))
        0: sat_pick = '0;
        1: sat_pick = '1;
        2: sat_pick = $urandom;
        default: sat_pick = $urandom_range(1, 1 << 20);
      endcase
      push_write(REG_SATURATION, sat_pick);
      for (int i = 0; i < 128; i++) begin
        case ($urandom_range(0, 7))
          0: q = $urandom;
          1: q = '0;
          2: q = '1;
          default: begin
            // keep most demand near the saturation size so the fraction moves
            if (sat_pick == '0 || sat_pick > 32'h7FFF_FFFF) q = $urandom;
            else q = $urandom_range(0, 2 * sat_pick);
          end
        endcase
        push_demand(q, calm);
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (request_queue.size() != 0 || dem_ch.valid || cfg_ch.valid || alloc_ch.valid ||
           pending_allocs.size() != 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0 && pending_allocs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
